@@ hdl/slcp_pkg.sv @@
// Shared types, constants and the level scaling function for the serial light
// command parser. No dependencies; every other file in hdl/ except slcp_in_reg uses this package.

package slcp_pkg;

    // Sliding window geometry
    localparam int WIN_BYTES = 8;
    localparam int WIN_IDX_W = $clog2(WIN_BYTES);
    localparam int FILL_W    = WIN_IDX_W + 1;

    // Packet header bytes
    localparam logic [7:0] HDR0 = 8'd65;
    localparam logic [7:0] HDR1 = 8'd86;
    localparam logic [7:0] HDR2 = 8'd65;

    // Register reset values
    localparam logic [7:0]  DEFAULT_MAX     = 8'd100;
    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd30000;

    // Channel count and result packing
    localparam int NUM_CH    = 4;
    localparam int OUT_BITS  = 2 + NUM_CH * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Config register indexes
    typedef enum logic [2:0] {
        REG_MAX_RED    = 3'd0,
        REG_MAX_GREEN  = 3'd1,
        REG_MAX_BLUE   = 3'd2,
        REG_MAX_YELLOW = 3'd3,
        REG_TIMEOUT    = 3'd4
    } t_reg_idx;

    // Command codes carried in the fourth window byte
    typedef enum logic [7:0] {
        CMD_OFF    = 8'd0,
        CMD_SET    = 8'd1,
        CMD_RESUME = 8'd2
    } t_cmd;

    typedef logic [NUM_CH-1:0][7:0] t_levels;

    // Config register contents
    typedef struct packed {
        t_levels     max_level;
        logic [15:0] timeout;
    } t_cfg;

    // Packet detection result for the current beat
    typedef struct packed {
        logic       packet;
        logic [7:0] cmd;
        t_levels    power;
    } t_win_status;

    // power * maxv / 255, truncated; exact reciprocal form for 16-bit products
    function automatic logic [7:0] scale_level(input logic [7:0] power,
                                               input logic [7:0] maxv);
        logic [15:0] prod;
        logic [15:0] sum;
        begin
            prod = {8'd0, power} * {8'd0, maxv};
            sum  = prod + {8'd0, prod[15:8]} + 16'd1;
            return sum[15:8];
        end
    endfunction

endpackage

@@ hdl/serial_light_command_parser.sv @@
// Serial light command parser, top level. An accepted input beat waits in the input
// register and loads into the result register unless the output stalls. Throughput:
// one beat per cycle unless m_axis_tready stalls; window, header match, four 8x8
// scalings and countdown all settle in the single stage between the two registers.
// Reset (i_rst_n low, synchronous): window empty, pause clear, countdown disarmed,
// levels zero, full-scale levels 100, resume timeout 30000. Depends on slcp_pkg.

module serial_light_command_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
    input  logic                            s_axis_tuser,   // [0] action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] paused, [1] packet_seen, [9:2] red_power, [17:10] green_power,
    // [25:18] blue_power, [33:26] yellow_power, upper bits zero
    output logic [slcp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_addr,
    input  logic [15:0]                     i_cfg_wdata
);

    slcp_pkg::t_cfg        w_cfg;
    slcp_pkg::t_win_status w_status;
    logic                  w_adv;
    logic                  w_in_valid;
    logic                  w_in_action;
    logic [7:0]            w_in_byte;

    slcp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    slcp_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_adv         (w_adv),
        .o_valid       (w_in_valid),
        .o_action      (w_in_action),
        .o_byte        (w_in_byte)
    );

    // Only received bytes enter the window
    slcp_window u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_in_valid && w_adv && !w_in_action),
        .i_byte   (w_in_byte),
        .o_status (w_status)
    );

    slcp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (w_in_valid),
        .i_action      (w_in_action),
        .i_status      (w_status),
        .i_cfg         (w_cfg),
        .o_adv         (w_adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ hdl/slcp_cfg_regs.sv @@
// Configuration registers: channel full-scale levels and resume timeout.
// Depends on slcp_pkg.

module slcp_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [15:0]         i_cfg_wdata,
    output slcp_pkg::t_cfg      o_cfg
);

    slcp_pkg::t_levels r_max;
    logic [15:0]       r_timeout;

    // Write one register per enabled cycle; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= {slcp_pkg::NUM_CH{slcp_pkg::DEFAULT_MAX}};
            r_timeout <= slcp_pkg::DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                slcp_pkg::REG_MAX_RED:    r_max[0]  <= i_cfg_wdata[7:0];
                slcp_pkg::REG_MAX_GREEN:  r_max[1]  <= i_cfg_wdata[7:0];
                slcp_pkg::REG_MAX_BLUE:   r_max[2]  <= i_cfg_wdata[7:0];
                slcp_pkg::REG_MAX_YELLOW: r_max[3]  <= i_cfg_wdata[7:0];
                slcp_pkg::REG_TIMEOUT:    r_timeout <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.max_level = r_max;
    assign o_cfg.timeout   = r_timeout;

endmodule

@@ hdl/slcp_in_reg.sv @@
// Input register stage: captures one beat (action and byte) per cycle while i_adv lets the held beat move on.
// Depends on slcp_pkg only by convention; no package items used.

module slcp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tuser,   // [0] action (1 = tick)
    input  logic       i_adv,
    output logic       o_valid,
    output logic       o_action,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       r_action;
    logic [7:0] r_byte;

    assign s_axis_tready = !r_valid || i_adv;

    // Refill whenever the held beat moves on or the stage is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_action <= s_axis_tuser;
            r_byte   <= s_axis_tdata;
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_byte   = r_byte;

endmodule

@@ hdl/slcp_window.sv @@
// Eight-byte sliding receive window with fill count and header match.
// Depends on slcp_pkg.

module slcp_window (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [7:0]              i_byte,
    output slcp_pkg::t_win_status   o_status
);

    localparam logic [slcp_pkg::FILL_W-1:0] FULL = slcp_pkg::FILL_W'(slcp_pkg::WIN_BYTES);

    logic [slcp_pkg::WIN_BYTES-1:0][7:0] r_win;
    logic [slcp_pkg::WIN_BYTES-1:0][7:0] n_win;
    logic [slcp_pkg::FILL_W-1:0]         r_fill;
    logic [slcp_pkg::FILL_W-1:0]         n_fill;
    logic                                w_match;

    // Append the byte, or shift out the oldest when full
    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_push) begin
            if (r_fill >= FULL) begin
                for (int i = 0; i < slcp_pkg::WIN_BYTES - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[slcp_pkg::WIN_BYTES-1] = i_byte;
            end else begin
                n_win[r_fill[slcp_pkg::WIN_IDX_W-1:0]] = i_byte;
                n_fill = r_fill + 1'b1;
            end
        end
        w_match = i_push && (n_fill == FULL) &&
                  (n_win[0] == slcp_pkg::HDR0) &&
                  (n_win[1] == slcp_pkg::HDR1) &&
                  (n_win[2] == slcp_pkg::HDR2);
    end

    // Window contents need no reset: only read once full
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // Empty the window after a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_match) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_status.packet = w_match;
    assign o_status.cmd    = n_win[3];
    assign o_status.power  = {n_win[7], n_win[6], n_win[5], n_win[4]};

endmodule

@@ hdl/slcp_ctrl.sv @@
// Pause flag, resume countdown, channel levels and the result register.
// Depends on slcp_pkg.

module slcp_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_action,
    input  slcp_pkg::t_win_status           i_status,
    input  slcp_pkg::t_cfg                  i_cfg,
    output logic                            o_adv,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] paused, [1] packet_seen, [9:2] red_power, [17:10] green_power,
    // [25:18] blue_power, [33:26] yellow_power, upper bits zero
    output logic [slcp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                            r_pause;
    logic                            n_pause;
    logic [15:0]                     r_cnt;
    logic [15:0]                     n_cnt;
    slcp_pkg::t_levels               r_level;
    slcp_pkg::t_levels               n_level;
    logic                            n_seen;
    logic                            w_step;
    logic                            r_out_valid;
    logic [slcp_pkg::OUT_DATA_W-1:0] r_out_data;

    assign o_adv  = !r_out_valid || m_axis_tready;
    assign w_step = i_in_valid && o_adv;

    // Next state for one beat
    always_comb begin
        n_pause = r_pause;
        n_cnt   = r_cnt;
        n_level = r_level;
        n_seen  = 1'b0;
        if (w_step) begin
            if (i_action) begin
                if (r_cnt != 16'd0) begin
                    n_cnt = r_cnt - 16'd1;
                    if (r_cnt == 16'd1) begin
                        n_pause = 1'b0;
                    end
                end
            end else if (i_status.packet) begin
                n_seen  = 1'b1;
                n_pause = 1'b1;
                n_cnt   = i_cfg.timeout;
                unique case (i_status.cmd)
                    slcp_pkg::CMD_OFF: begin
                        n_level = '0;
                    end
                    slcp_pkg::CMD_SET: begin
                        for (int c = 0; c < slcp_pkg::NUM_CH; c++) begin
                            n_level[c] = slcp_pkg::scale_level(i_status.power[c],
                                                               i_cfg.max_level[c]);
                        end
                    end
                    slcp_pkg::CMD_RESUME: begin
                        n_pause = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause     <= 1'b0;
            r_cnt       <= 16'd0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pause <= n_pause;
            r_cnt   <= n_cnt;
            r_level <= n_level;
            if (o_adv) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= slcp_pkg::OUT_DATA_W'({n_level[3], n_level[2], n_level[1],
                                                 n_level[0], n_seen, n_pause});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Armed countdown drops by one on each tick
    a_cnt_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && i_action && r_cnt != 16'd0) |=> (r_cnt == $past(r_cnt) - 16'd1))
        else $error("countdown did not decrement on tick");

    // Pause only rises on a packet
    a_pause_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_pause && n_pause) |-> (w_step && !i_action && i_status.packet))
        else $error("pause set without packet");

    // A packet always rearms the countdown
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !i_action && i_status.packet) |=> (r_cnt == $past(i_cfg.timeout)))
        else $error("countdown not rearmed by packet");

    // Levels change only on a packet beat
    a_level_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_step && !i_action && i_status.packet) |=> $stable(r_level))
        else $error("channel levels changed without packet");

endmodule
